FILE: design/b64d_pkg.sv
package b64d_pkg;

	localparam int COUNT_BITS  = 24;
	localparam int CNT_OUT_W   = 24;
	localparam int MAX_RES     = 4;
	localparam int FIFO_DEPTH  = 8;
	localparam int PTR_W       = $clog2(FIFO_DEPTH);
	localparam int FCNT_W      = $clog2(FIFO_DEPTH + 1);
	localparam int NRES_W      = $clog2(MAX_RES + 1);

	localparam logic [7:0] PAD_CHAR = 8'h3D;
	localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = {COUNT_BITS{1'b1}};

	typedef struct packed {
		logic [7:0]           data_byte;
		logic                 byte_valid;
		logic                 string_done;
		logic                 decode_error;
		logic [CNT_OUT_W-1:0] byte_count;
		logic                 last_of_item;
	} result_t;

	typedef result_t [MAX_RES-1:0] res_vec_t;

	typedef struct packed {
		logic                push;
		logic [NRES_W-1:0]   num;
	} push_ctl_t;

	// bit 6 flags a character of the alphabet, bits 5:0 carry its value
	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		logic [6:0] r;
		r = 7'd0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r = {1'b1, 6'(c - 8'h41)};
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			r = {1'b1, 6'(c - 8'h61 + 8'd26)};
		end else if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 6'(c - 8'h30 + 8'd52)};
		end else if (c == 8'h2B) begin
			r = {1'b1, 6'd62};
		end else if (c == 8'h2F) begin
			r = {1'b1, 6'd63};
		end
		return r;
	endfunction

	function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] cnt,
		input logic [NRES_W-1:0] k);
		logic [COUNT_BITS:0] s;
		s = {1'b0, cnt} + (COUNT_BITS+1)'(k);
		if (s[COUNT_BITS]) begin
			return COUNT_LIMIT;
		end
		return s[COUNT_BITS-1:0];
	endfunction

endpackage

FILE: design/b64d_decode.sv
module b64d_decode (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [7:0]             char_code,
	input  logic                   end_of_string,
	input  logic                   room,
	output b64d_pkg::push_ctl_t    push_ctl,
	output b64d_pkg::res_vec_t     res
);

	logic                            valid_s1;
	logic [7:0]                      char_s1;
	logic                            eos_s1;
	logic [23:0]                     acc_q, acc_n, acc_sh;
	logic [1:0]                      sext_q, sext_n;
	logic                            pad_q, pad_n;
	logic                            err_q, err_n;
	logic [b64d_pkg::COUNT_BITS-1:0] bytes_q, bytes_n, bytes_end;
	logic [6:0]                      sx;
	logic [7:0]                      d [3];
	logic [b64d_pkg::NRES_W-1:0]     nb, num;
	logic                            advance;
	b64d_pkg::result_t               status;

	assign advance  = valid_s1 && room;
	assign in_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			char_s1 <= char_code;
			eos_s1  <= end_of_string;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			sext_q  <= '0;
			pad_q   <= 1'b0;
			err_q   <= 1'b0;
			bytes_q <= '0;
		end else if (advance) begin
			acc_q   <= acc_n;
			sext_q  <= sext_n;
			pad_q   <= pad_n;
			err_q   <= err_n;
			bytes_q <= bytes_n;
		end
	end

	always_comb begin
		sx     = b64d_pkg::sextet_of(char_s1);
		acc_sh = {acc_q[17:0], sx[5:0]};
		acc_n  = acc_q;
		sext_n = sext_q;
		pad_n  = pad_q;
		err_n  = err_q;
		d[0]   = 8'd0;
		d[1]   = 8'd0;
		d[2]   = 8'd0;
		nb     = '0;
		if (!pad_q) begin
			if (char_s1 == b64d_pkg::PAD_CHAR) begin
				case (sext_q)
					2'd1: begin
						err_n = 1'b1;
					end
					2'd2: begin
						d[0] = acc_q[11:4];
						nb   = b64d_pkg::NRES_W'(1);
					end
					2'd3: begin
						d[0] = acc_q[17:10];
						d[1] = acc_q[9:2];
						nb   = b64d_pkg::NRES_W'(2);
					end
					default: ;
				endcase
				pad_n  = 1'b1;
				acc_n  = '0;
				sext_n = '0;
			end else if (sx[6]) begin
				if (sext_q == 2'd3) begin
					d[0]   = acc_sh[23:16];
					d[1]   = acc_sh[15:8];
					d[2]   = acc_sh[7:0];
					nb     = b64d_pkg::NRES_W'(3);
					acc_n  = '0;
					sext_n = '0;
				end else begin
					acc_n  = acc_sh;
					sext_n = sext_q + 2'd1;
				end
			end
		end

		bytes_end = b64d_pkg::sat_add(bytes_q, nb);
		bytes_n   = bytes_end;

		status.data_byte    = 8'd0;
		status.byte_valid   = 1'b0;
		status.string_done  = 1'b1;
		status.decode_error = err_n;
		status.byte_count   = b64d_pkg::CNT_OUT_W'(bytes_end);
		status.last_of_item = 1'b0;

		res = '0;
		for (int k = 0; k < 3; k++) begin
			res[k].data_byte  = d[k];
			res[k].byte_valid = 1'b1;
			res[k].byte_count = b64d_pkg::CNT_OUT_W'(
				b64d_pkg::sat_add(bytes_q, b64d_pkg::NRES_W'(k + 1)));
		end

		num = nb;
		if (eos_s1) begin
			for (int k = 0; k < b64d_pkg::MAX_RES; k++) begin
				if (b64d_pkg::NRES_W'(k) == nb) begin
					res[k] = status;
				end
			end
			num     = nb + b64d_pkg::NRES_W'(1);
			acc_n   = '0;
			sext_n  = '0;
			pad_n   = 1'b0;
			err_n   = 1'b0;
			bytes_n = '0;
		end

		for (int k = 0; k < b64d_pkg::MAX_RES; k++) begin
			if (b64d_pkg::NRES_W'(k + 1) == num) begin
				res[k].last_of_item = 1'b1;
			end
		end

		push_ctl.push = advance;
		push_ctl.num  = num;
	end

endmodule

FILE: design/b64d_fifo.sv
module b64d_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  b64d_pkg::push_ctl_t push_ctl,
	input  b64d_pkg::res_vec_t  res,
	output logic                room,
	output logic                out_valid,
	input  logic                out_stall,
	output b64d_pkg::result_t   head
);

	b64d_pkg::result_t               mem [b64d_pkg::FIFO_DEPTH];
	logic [b64d_pkg::PTR_W-1:0]      wr_ptr_q, rd_ptr_q;
	logic [b64d_pkg::FCNT_W-1:0]     count_q;
	logic                            pop;
	logic [b64d_pkg::NRES_W-1:0]     nwr;

	assign room      = count_q <= b64d_pkg::FCNT_W'(b64d_pkg::FIFO_DEPTH - b64d_pkg::MAX_RES);
	assign out_valid = count_q != '0;
	assign pop       = out_valid && !out_stall;
	assign nwr       = push_ctl.push ? push_ctl.num : '0;
	assign head      = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + b64d_pkg::PTR_W'(nwr);
			rd_ptr_q <= rd_ptr_q + b64d_pkg::PTR_W'(pop);
			count_q  <= count_q + b64d_pkg::FCNT_W'(nwr) - b64d_pkg::FCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < b64d_pkg::MAX_RES; k++) begin
			if (b64d_pkg::NRES_W'(k) < nwr) begin
				mem[wr_ptr_q + b64d_pkg::PTR_W'(k)] <= res[k];
			end
		end
	end

endmodule

FILE: design/base64_stream_decoder_top.sv
// Base64 stream decoder: takes one character word per cycle and returns decoded bytes
// and one status word at each end of string, one result word per cycle. A character
// is held in the input register, where it is decoded and its zero to four results
// are written at once into an eight-entry result queue; the oldest result is visible at
// the output the cycle after. The input stalls only while the queue holds more than four
// results, so a character can be accepted every cycle as long as the output drains;
// the single-word output port sets the sustained rate at one result per cycle.
module base64_stream_decoder_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     char_code,
	input  logic                           end_of_string,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [7:0]                     data_byte,
	output logic                           byte_valid,
	output logic                           string_done,
	output logic                           decode_error,
	output logic [b64d_pkg::CNT_OUT_W-1:0] byte_count,
	output logic                           last_of_item
);

	b64d_pkg::push_ctl_t push_ctl;
	b64d_pkg::res_vec_t  res;
	b64d_pkg::result_t   head;
	logic                room;

	b64d_decode u_decode (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.char_code     (char_code),
		.end_of_string (end_of_string),
		.room          (room),
		.push_ctl      (push_ctl),
		.res           (res)
	);

	b64d_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_ctl  (push_ctl),
		.res       (res),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign data_byte    = head.data_byte;
	assign byte_valid   = head.byte_valid;
	assign string_done  = head.string_done;
	assign decode_error = head.decode_error;
	assign byte_count   = head.byte_count;
	assign last_of_item = head.last_of_item;

endmodule

FILE: design/b64d_checker.sv
module b64d_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [7:0]                     data_byte,
	input logic                           byte_valid,
	input logic                           string_done,
	input logic                           decode_error,
	input logic [b64d_pkg::CNT_OUT_W-1:0] byte_count,
	input logic                           last_of_item
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output word dropped while stalled");

	a_byte_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_valid |-> !decode_error && !string_done)
		else $error("byte word carries status bits");

	a_status_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_valid |-> string_done && last_of_item && data_byte == 8'd0)
		else $error("malformed status word");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && byte_valid && !last_of_item ##1 out_valid && byte_valid
		|-> byte_count == $past(byte_count) + b64d_pkg::CNT_OUT_W'(1)
			|| byte_count == $past(byte_count))
		else $error("byte count skipped within one character");

endmodule

bind base64_stream_decoder_top b64d_checker u_b64d_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.data_byte    (data_byte),
	.byte_valid   (byte_valid),
	.string_done  (string_done),
	.decode_error (decode_error),
	.byte_count   (byte_count),
	.last_of_item (last_of_item)
);

FILE: tb/base64_stream_decoder_top_tb.sv
`timescale 1ns / 1ps

module base64_stream_decoder_top_tb;

	localparam string ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
	localparam logic [7:0] NUL_CHAR = 8'h00;
	localparam logic [7:0] TOP_CHAR = 8'hFF;
	localparam int MAX_WAIT = 17;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 32;
	localparam int TOTAL_CHARS = 260;

	logic                           clk;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_stall;
	logic [7:0]                     char_code;
	logic                           end_of_string;
	logic                           out_valid;
	logic                           out_stall;
	logic [7:0]                     data_byte;
	logic                           byte_valid;
	logic                           string_done;
	logic                           decode_error;
	logic [b64d_pkg::CNT_OUT_W-1:0] byte_count;
	logic                           last_of_item;

	base64_stream_decoder_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.char_code     (char_code),
		.end_of_string (end_of_string),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.data_byte     (data_byte),
		.byte_valid    (byte_valid),
		.string_done   (string_done),
		.decode_error  (decode_error),
		.byte_count    (byte_count),
		.last_of_item  (last_of_item)
	);

	class decoded_word_board;
		logic [23:0]                     group_bits;
		int                              group_len;
		bit                              pad_seen;
		bit                              pad_error;
		logic [b64d_pkg::COUNT_BITS-1:0] decoded_total;
		b64d_pkg::result_t               pending_words[$];
		int                              failures;
		int                              strings_seen;
		int                              bytes_seen;
		int                              errors_seen;
		int                              words_checked;

		function new();
			clear_string();
			failures = 0;
			strings_seen = 0;
			bytes_seen = 0;
			errors_seen = 0;
			words_checked = 0;
		endfunction

		function void clear_string();
			group_bits = '0;
			group_len = 0;
			pad_seen = 0;
			pad_error = 0;
			decoded_total = '0;
		endfunction

		function int alphabet_value(logic [7:0] c);
			for (int i = 0; i < 64; i++) begin
				if (ALPHABET[i] == c) begin
					return i;
				end
			end
			return -1;
		endfunction

		function void push_byte(logic [7:0] d);
			b64d_pkg::result_t r;
			if (decoded_total != b64d_pkg::COUNT_LIMIT) begin
				decoded_total = decoded_total + 1'b1;
			end
			r = '0;
			r.data_byte = d;
			r.byte_valid = 1'b1;
			r.byte_count = b64d_pkg::CNT_OUT_W'(decoded_total);
			pending_words.push_back(r);
			bytes_seen++;
		endfunction

		function void take_char(logic [7:0] c, logic eos);
			int first;
			int v;
			b64d_pkg::result_t r;
			first = pending_words.size();
			if (!pad_seen) begin
				if (c == b64d_pkg::PAD_CHAR) begin
					case (group_len)
						1: pad_error = 1;
						2: push_byte(group_bits[11:4]);
						3: begin
							push_byte(group_bits[17:10]);
							push_byte(group_bits[9:2]);
						end
						default: ;
					endcase
					pad_seen = 1;
					group_bits = '0;
					group_len = 0;
				end else begin
					v = alphabet_value(c);
					if (v >= 0) begin
						group_bits = {group_bits[17:0], 6'(v)};
						group_len++;
						if (group_len == 4) begin
							push_byte(group_bits[23:16]);
							push_byte(group_bits[15:8]);
							push_byte(group_bits[7:0]);
							group_bits = '0;
							group_len = 0;
						end
					end
				end
			end
			if (eos) begin
				r = '0;
				r.string_done = 1'b1;
				r.decode_error = pad_error;
				r.byte_count = b64d_pkg::CNT_OUT_W'(decoded_total);
				pending_words.push_back(r);
				strings_seen++;
				if (pad_error) begin
					errors_seen++;
				end
				clear_string();
			end
			if (pending_words.size() > first) begin
				r = pending_words.pop_back();
				r.last_of_item = 1'b1;
				pending_words.push_back(r);
			end
		endfunction

		function void check_word(b64d_pkg::result_t got);
			b64d_pkg::result_t exp;
			words_checked++;
			if (pending_words.size() == 0) begin
				$error("unexpected word: data_byte %0h byte_valid %0b string_done %0b",
					got.data_byte, got.byte_valid, got.string_done);
				failures++;
				return;
			end
			exp = pending_words.pop_front();
			if (got.data_byte !== exp.data_byte) begin
				$error("data_byte: expected %0h, got %0h", exp.data_byte, got.data_byte);
				failures++;
			end
			if (got.byte_valid !== exp.byte_valid) begin
				$error("byte_valid: expected %0b, got %0b", exp.byte_valid, got.byte_valid);
				failures++;
			end
			if (got.string_done !== exp.string_done) begin
				$error("string_done: expected %0b, got %0b", exp.string_done, got.string_done);
				failures++;
			end
			if (got.decode_error !== exp.decode_error) begin
				$error("decode_error: expected %0b, got %0b", exp.decode_error,
					got.decode_error);
				failures++;
			end
			if (got.byte_count !== exp.byte_count) begin
				$error("byte_count: expected %0d, got %0d", exp.byte_count, got.byte_count);
				failures++;
			end
			if (got.last_of_item !== exp.last_of_item) begin
				$error("last_of_item: expected %0b, got %0b", exp.last_of_item,
					got.last_of_item);
				failures++;
			end
		endfunction

		function int outstanding();
			return pending_words.size();
		endfunction
	endclass

	decoded_word_board board = new();

	int chars_sent = 0;
	bit tx_fast = 0;
	bit rx_fast = 0;
	bit hold_req = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("base64_stream_decoder_top_tb: FAIL");
		$finish;
	end

	function automatic logic [7:0] alpha_char();
		return ALPHABET[$urandom_range(0, 63)];
	endfunction

	task automatic send_char(input logic [7:0] c, input logic eos);
		int gap;
		gap = tx_fast ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		char_code <= c;
		end_of_string <= eos;
		do @(posedge clk); while (in_stall);
		board.take_char(c, eos);
		chars_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_char(s[i], i == s.len() - 1);
		end
	endtask

	task automatic random_string(input bit force_fast);
		logic [7:0] seq[$];
		logic [7:0] junk;
		int style;
		int n;
		style = $urandom_range(0, 9);
		if (style == 0) begin
			n = $urandom_range(1, 12);
			repeat (n) seq.push_back(8'($urandom_range(0, 255)));
		end else begin
			n = $urandom_range(0, 5) * 4 + $urandom_range(0, 3);
			repeat (n) begin
				if ($urandom_range(0, 7) == 0) begin
					do junk = 8'($urandom_range(0, 255));
					while (board.alphabet_value(junk) >= 0 || junk == b64d_pkg::PAD_CHAR);
					seq.push_back(junk);
				end
				seq.push_back(alpha_char());
			end
			if (style <= 6) begin
				seq.push_back(b64d_pkg::PAD_CHAR);
				if ($urandom_range(0, 1)) begin
					seq.push_back(b64d_pkg::PAD_CHAR);
				end
				repeat ($urandom_range(0, 3)) seq.push_back(8'($urandom_range(0, 255)));
			end
			if (seq.size() == 0) begin
				seq.push_back(alpha_char());
			end
		end
		tx_fast = force_fast || ($urandom_range(0, 3) == 0);
		foreach (seq[i]) begin
			send_char(seq[i], i == seq.size() - 1);
		end
	endtask

	initial begin
		b64d_pkg::result_t got;
		int gap;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 15) == 0) begin
				rx_fast = !rx_fast;
			end
			gap = hold_req ? HOLD_CYCLES : (rx_fast ? 0 : $urandom_range(0, MAX_WAIT));
			hold_req = 0;
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			got.data_byte = data_byte;
			got.byte_valid = byte_valid;
			got.string_done = string_done;
			got.decode_error = decode_error;
			got.byte_count = byte_count;
			got.last_of_item = last_of_item;
			board.check_word(got);
		end
	end

	initial begin
		bit paused;
		bit held;
		paused = 0;
		held = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		char_code <= '0;
		end_of_string <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_text("TWFu");
		send_text("TQ==");
		send_text("TWE=");
		send_text("T=A");
		send_text("+/+/=");
		send_char(NUL_CHAR, 1'b0);
		send_char(TOP_CHAR, 1'b0);
		send_text("Zz9");

		while (chars_sent < TOTAL_CHARS) begin
			if (!paused && chars_sent > 110) begin
				paused = 1;
				// hold until the output side has drained
				in_valid <= 1'b0;
				while (board.outstanding() != 0) @(posedge clk);
			end
			if (!held && chars_sent > 200) begin
				held = 1;
				hold_req = 1;
				repeat (4) random_string(1'b1);
			end else begin
				random_string(1'b0);
			end
		end

		in_valid <= 1'b0;
		while (board.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d characters in %0d strings: %0d decoded bytes, %0d padding errors",
			chars_sent, board.strings_seen, board.bytes_seen, board.errors_seen);
		$display("%0d output words checked", board.words_checked);
		if (board.failures == 0) begin
			$display("base64_stream_decoder_top_tb: PASS");
		end else begin
			$display("base64_stream_decoder_top_tb: FAIL");
		end
		$finish;
	end

endmodule
